### src/sps_pkg.sv
// shared types and constants of the sparse-set id registry
package sps_pkg;

	localparam int MAX_IDS = 1024;
	localparam int ID_W    = 10;
	localparam int CNT_W   = $clog2(MAX_IDS) + 1;
	localparam int SLOT_W  = CNT_W;
	localparam int ADDR_W  = $clog2(MAX_IDS);

	localparam logic [SLOT_W-1:0] SLOT_EMPTY = '1;

	typedef enum logic [1:0] {
		FUNC_CREATE  = 2'd0,
		FUNC_DESTROY = 2'd1,
		FUNC_QUERY   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DEAD = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOT,
		S_CMP,
		S_PATCH,
		S_OUT
	} state_t;

	// read and write requests toward the sparse and dense memories
	typedef struct packed {
		logic [ADDR_W-1:0] sp_raddr;
		logic              sp_we;
		logic [ADDR_W-1:0] sp_waddr;
		logic [SLOT_W-1:0] sp_wdata;
		logic [ADDR_W-1:0] dn_raddr;
		logic              dn_we;
		logic [ADDR_W-1:0] dn_waddr;
		logic [ID_W-1:0]   dn_wdata;
	} mem_req_t;

	// counters visible to the top level
	typedef struct packed {
		logic [CNT_W-1:0] live_count;
		logic [CNT_W-1:0] next_free_id;
	} ctr_stat_t;

endpackage

### src/sps_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### src/sps_ctrl.sv
// sequencer: create, destroy and query over the sparse and dense memories
module sps_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               func,
	input  logic [sps_pkg::ID_W-1:0] target_id,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [sps_pkg::ID_W-1:0] result_id,
	output logic                     alive,
	output logic [1:0]               status,
	output sps_pkg::mem_req_t        req,
	input  logic [sps_pkg::SLOT_W-1:0] sp_rdata,
	input  logic [sps_pkg::ID_W-1:0]   dn_rdata,
	output sps_pkg::ctr_stat_t       stat
);
	import sps_pkg::*;

	state_t            state_q, state_d;
	func_t             func_q, func_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [ID_W-1:0]   back_q, back_d;
	logic              pre_q, pre_d;
	logic [CNT_W-1:0]  live_cnt_q, live_cnt_d;
	logic [CNT_W-1:0]  next_id_q, next_id_d;
	logic [CNT_W-1:0]  last_cnt;
	logic [ID_W-1:0]   res_id_q, res_id_d;
	logic              res_alive_q, res_alive_d;
	status_t           res_status_q, res_status_d;
	logic              out_valid_q, out_valid_d;
	logic [ID_W-1:0]   out_id_q;
	logic              out_alive_q;
	status_t           out_status_q;
	logic              out_load;
	logic              is_live;

	assign last_cnt = live_cnt_q - CNT_W'(1);
	assign is_live  = pre_q && (dn_rdata == id_q);

	// next state, memory requests and result
	always_comb begin
		state_d      = state_q;
		func_d       = func_q;
		id_d         = id_q;
		slot_d       = slot_q;
		back_d       = back_q;
		pre_d        = pre_q;
		live_cnt_d   = live_cnt_q;
		next_id_d    = next_id_q;
		res_id_d     = res_id_q;
		res_alive_d  = res_alive_q;
		res_status_d = res_status_q;
		out_load     = 1'b0;
		in_ready     = (state_q == S_IDLE);
		req          = '0;
		case (state_q)
			S_IDLE: begin
				// look up the sparse slot and the last dense entry up front
				req.sp_raddr = target_id[ADDR_W-1:0];
				req.dn_raddr = last_cnt[ADDR_W-1:0];
				if (in_valid) begin
					func_d       = func_t'(func);
					id_d         = target_id;
					res_id_d     = target_id;
					res_alive_d  = 1'b0;
					res_status_d = ST_OK;
					case (func_t'(func))
						FUNC_CREATE: begin
							state_d = S_OUT;
							if (next_id_q >= CNT_W'(MAX_IDS)) begin
								res_id_d     = '0;
								res_status_d = ST_FULL;
							end else begin
								req.dn_we    = 1'b1;
								req.dn_waddr = live_cnt_q[ADDR_W-1:0];
								req.dn_wdata = next_id_q[ID_W-1:0];
								req.sp_we    = 1'b1;
								req.sp_waddr = next_id_q[ADDR_W-1:0];
								req.sp_wdata = live_cnt_q;
								live_cnt_d   = live_cnt_q + CNT_W'(1);
								next_id_d    = next_id_q + CNT_W'(1);
								res_id_d     = next_id_q[ID_W-1:0];
								res_alive_d  = 1'b1;
							end
						end
						FUNC_DESTROY, FUNC_QUERY: begin
							state_d = S_SLOT;
						end
						default: begin
							state_d = S_OUT;
						end
					endcase
				end
			end
			S_SLOT: begin
				// sparse slot is back: range checks, then fetch the dense entry
				slot_d       = sp_rdata;
				back_d       = dn_rdata;
				req.dn_raddr = sp_rdata[ADDR_W-1:0];
				pre_d        = ({1'b0, id_q} < next_id_q) && (sp_rdata != SLOT_EMPTY)
					&& (sp_rdata < live_cnt_q);
				state_d      = S_CMP;
			end
			S_CMP: begin
				state_d = S_OUT;
				if (func_q == FUNC_QUERY) begin
					res_alive_d = is_live;
				end else if (is_live) begin
					// move the last entry into the freed slot
					req.dn_we    = 1'b1;
					req.dn_waddr = slot_q[ADDR_W-1:0];
					req.dn_wdata = back_q;
					req.sp_we    = 1'b1;
					req.sp_waddr = id_q[ADDR_W-1:0];
					req.sp_wdata = SLOT_EMPTY;
					live_cnt_d   = last_cnt;
					if (back_q != id_q) begin
						state_d = S_PATCH;
					end
				end else begin
					res_status_d = ST_DEAD;
				end
			end
			S_PATCH: begin
				// point the moved id at its new slot
				req.sp_we    = 1'b1;
				req.sp_waddr = back_q[ADDR_W-1:0];
				req.sp_wdata = slot_q;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_valid_d = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_cnt_q  <= '0;
			next_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			live_cnt_q  <= live_cnt_d;
			next_id_q   <= next_id_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working and output payload
	always_ff @(posedge clk) begin
		func_q       <= func_d;
		id_q         <= id_d;
		slot_q       <= slot_d;
		back_q       <= back_d;
		pre_q        <= pre_d;
		res_id_q     <= res_id_d;
		res_alive_q  <= res_alive_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_id_q     <= res_id_q;
			out_alive_q  <= res_alive_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign result_id         = out_id_q;
	assign alive             = out_alive_q;
	assign status            = out_status_q;
	assign stat.live_count   = live_cnt_q;
	assign stat.next_free_id = next_id_q;

endmodule

### src/sparse_set_id_registry_core.sv
// top level of the sparse-set id registry: sequencer and the two memories
// Sparse-set registry of live ids. Create issues ids in increasing order and
// never reuses one; destroy swaps the last dense entry into the freed slot;
// query reports liveness. One transaction is worked on at a time: a create
// or an unused code goes straight to the output state, a query passes the
// slot and compare states, and a destroy passes the slot and compare states
// and a patch state when another entry must be moved. This is set by the
// chain of dependent registered reads of the sparse and then the dense memory
// and by the single write port of the sparse memory. A finished result sits
// in an output register; the next transaction is accepted while it waits.
module sparse_set_id_registry_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               func,
	input  logic [sps_pkg::ID_W-1:0] target_id,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [sps_pkg::ID_W-1:0] result_id,
	output logic                     alive,
	output logic [1:0]               status
);
	import sps_pkg::*;

	mem_req_t          req;
	ctr_stat_t         stat;
	logic [SLOT_W-1:0] sp_rdata;
	logic [ID_W-1:0]   dn_rdata;

	// sequencer
	sps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.target_id (target_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_id (result_id),
		.alive     (alive),
		.status    (status),
		.req       (req),
		.sp_rdata  (sp_rdata),
		.dn_rdata  (dn_rdata),
		.stat      (stat)
	);

	// sparse map: id to dense slot
	sps_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_IDS)) u_sparse (
		.clk   (clk),
		.we    (req.sp_we),
		.waddr (req.sp_waddr),
		.wdata (req.sp_wdata),
		.raddr (req.sp_raddr),
		.rdata (sp_rdata)
	);

	// dense packed list of live ids
	sps_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_dense (
		.clk   (clk),
		.we    (req.dn_we),
		.waddr (req.dn_waddr),
		.wdata (req.dn_wdata),
		.raddr (req.dn_raddr),
		.rdata (dn_rdata)
	);

	// live ids never outnumber issued ids
	a_live_le_issued: assert property (@(posedge clk) disable iff (!arst_n)
		stat.live_count <= stat.next_free_id)
		else $error("live count above issued id count");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a transaction while busy");

	// exhausted create reports no id
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (!alive && result_id == '0))
		else $error("full status with id or alive set");

	// issued id counter moves only by a single step
	a_issue_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.next_free_id != $past(stat.next_free_id)) |->
		(stat.next_free_id == $past(stat.next_free_id) + CNT_W'(1)))
		else $error("id counter jumped");

endmodule

### bench/testbench.sv
// self-checking testbench of the sparse-set id registry core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	// the fourth func code is not decoded by the block
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RESULT_LATENCY = 10;

	typedef struct packed {
		logic [ID_W-1:0] rid;
		logic            alive;
		logic [1:0]      status;
	} reply_t;

	// mirror of the registry state plus the replies still owed by the block
	class id_registry_tracker;
		logic [CNT_W-1:0]  next_free;
		logic [CNT_W-1:0]  live_cnt;
		logic [ID_W-1:0]   dense [MAX_IDS];
		logic [SLOT_W-1:0] sparse [MAX_IDS];
		reply_t            expected_replies [$];
		int                errors;
		int                checked;

		function new();
			next_free = '0;
			live_cnt  = '0;
			errors    = 0;
			checked   = 0;
		endfunction

		function bit is_live(logic [ID_W-1:0] id);
			logic [SLOT_W-1:0] slot;
			if ({1'b0, id} >= next_free)
				return 1'b0;
			slot = sparse[id];
			if (slot == SLOT_EMPTY || slot >= live_cnt)
				return 1'b0;
			return dense[slot[ADDR_W-1:0]] == id;
		endfunction

		// apply one transaction to the mirror and return the reply it must produce
		function reply_t predict_reply(logic [1:0] f, logic [ID_W-1:0] id);
			reply_t            r;
			logic [SLOT_W-1:0] slot;
			logic [CNT_W-1:0]  last;
			logic [ID_W-1:0]   back;
			r.rid    = id;
			r.alive  = 1'b0;
			r.status = ST_OK;
			case (f)
				FUNC_CREATE: begin
					if (next_free >= CNT_W'(MAX_IDS) || live_cnt >= CNT_W'(MAX_IDS)) begin
						r.rid    = '0;
						r.status = ST_FULL;
					end else begin
						dense[live_cnt[ADDR_W-1:0]]   = next_free[ID_W-1:0];
						sparse[next_free[ADDR_W-1:0]] = live_cnt;
						r.rid     = next_free[ID_W-1:0];
						r.alive   = 1'b1;
						live_cnt  = live_cnt + CNT_W'(1);
						next_free = next_free + CNT_W'(1);
					end
				end
				FUNC_DESTROY: begin
					if (!is_live(id)) begin
						r.status = ST_DEAD;
					end else begin
						// move the last dense entry into the freed slot
						slot = sparse[id];
						last = live_cnt - CNT_W'(1);
						back = dense[last[ADDR_W-1:0]];
						dense[slot[ADDR_W-1:0]] = back;
						live_cnt   = last;
						sparse[id] = SLOT_EMPTY;
						if (back != id)
							sparse[back] = slot;
					end
				end
				FUNC_QUERY: r.alive = is_live(id);
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(logic [1:0] f, logic [ID_W-1:0] id);
			expected_replies.push_back(predict_reply(f, id));
		endfunction

		task report_mismatch(input string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_response(logic [ID_W-1:0] rid, logic alv, logic [1:0] st);
			reply_t e;
			if (expected_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected result id=%0d alive=%0b status=%0d",
					rid, alv, st));
				return;
			end
			e = expected_replies.pop_front();
			checked++;
			if (rid !== e.rid)
				report_mismatch($sformatf("result_id %0d, expected %0d", rid, e.rid));
			if (alv !== e.alive)
				report_mismatch($sformatf("alive %0b, expected %0b (id %0d)",
					alv, e.alive, e.rid));
			if (st !== e.status)
				report_mismatch($sformatf("status %0d, expected %0d (id %0d)",
					st, e.status, e.rid));
		endtask

		function int pending_count();
			return expected_replies.size();
		endfunction

		// a live id right now: the last dense entry, or a random one
		function logic [ID_W-1:0] pick_live(bit take_last);
			logic [CNT_W-1:0] top;
			top = live_cnt - CNT_W'(1);
			if (take_last)
				return dense[top[ADDR_W-1:0]];
			return dense[ADDR_W'($urandom_range(int'(top), 0))];
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [1:0]      func;
	logic [ID_W-1:0] target_id;
	logic            out_valid;
	logic            out_ready;
	logic [ID_W-1:0] result_id;
	logic            alive;
	logic [1:0]      status;

	id_registry_tracker sb = new();
	bit steady = 1'b0;

	sparse_set_id_registry_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.target_id (target_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_id (result_id),
		.alive     (alive),
		.status    (status)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// offer one transaction and hold it until the block takes it; pause at random outside steady stretches
	task send(input logic [1:0] f, input logic [ID_W-1:0] id);
		in_valid  <= 1'b1;
		func      <= f;
		target_id <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(f, id);
		if (!steady && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	// stop offering until every owed result has come back
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	// one random transaction, mostly creates so the id space runs out
	task send_random();
		int unsigned     r;
		logic [ID_W-1:0] id;
		r  = $urandom_range(99);
		id = ID_W'($urandom_range(MAX_IDS - 1, 0));
		if (r < 74) begin
			send(FUNC_CREATE, id);
		end else if (r < 88) begin
			if (sb.live_cnt != 0 && $urandom_range(9) < 8)
				id = sb.pick_live($urandom_range(3) == 0);
			send(FUNC_DESTROY, id);
		end else if (r < 97) begin
			if (sb.live_cnt != 0 && $urandom_range(9) < 6)
				id = sb.pick_live(1'b0);
			else if (sb.next_free != 0 && $urandom_range(1) == 0)
				id = ID_W'($urandom_range(int'(sb.next_free) - 1, 0));
			send(FUNC_QUERY, id);
		end else begin
			send(FUNC_UNUSED, id);
		end
	endtask

	// stimulus and end of run
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		func      <= FUNC_CREATE;
		target_id <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty registry, swaps, double destroy, unused code
		send(FUNC_QUERY, 10'd0);
		send(FUNC_DESTROY, 10'd1023);
		send(FUNC_UNUSED, 10'd1023);
		send(FUNC_CREATE, 10'd1023);
		send(FUNC_CREATE, 10'h155);
		send(FUNC_CREATE, 10'h2aa);
		send(FUNC_QUERY, 10'd1);
		send(FUNC_DESTROY, 10'd0);
		send(FUNC_QUERY, 10'd0);
		send(FUNC_QUERY, 10'd2);
		send(FUNC_DESTROY, 10'd0);
		send(FUNC_DESTROY, 10'd1);
		send(FUNC_QUERY, 10'd2);
		send(FUNC_DESTROY, 10'd2);
		send(FUNC_QUERY, 10'd2);
		send(FUNC_CREATE, 10'd0);
		send(FUNC_UNUSED, 10'd0);
		send(FUNC_QUERY, 10'd3);
		send(FUNC_QUERY, 10'd1023);
		send(FUNC_DESTROY, 10'd3);
		send(FUNC_QUERY, 10'h2aa);
		drain();

		// random traffic with a stretch free of pauses and stalls and a mid-run drain
		for (int n = 0; n < 1530; n++) begin
			steady = (n >= 400 && n < 700);
			if (n == 760)
				drain();
			send_random();
		end
		steady = 1'b0;

		drain();
		repeat (RESULT_LATENCY) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result side: check every accepted result, stall at random and once for long
	initial begin
		int hold_left;
		bit did_hold;
		hold_left = 0;
		did_hold  = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && out_ready)
					sb.check_response(result_id, alive, status);
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else if (!did_hold && sb.checked >= 900) begin
					did_hold  = 1'b1;
					hold_left = 250;
					out_ready <= 1'b0;
				end else begin
					out_ready <= steady || ($urandom_range(99) >= 9);
				end
			end
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
